@@ rtl/packet_payload_string_extractor_defines.svh @@
// Assertion macros for the packet payload string extractor.
// Used by the port-level checker; depends on nothing else.
`ifndef PACKET_PAYLOAD_STRING_EXTRACTOR_DEFINES_SVH
`define PACKET_PAYLOAD_STRING_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ppse_pkg.sv @@
// Package for the packet payload string extractor: payload structs,
// result kind codes, protocol constants and controller/datapath structs.
// Depends on nothing.
package ppse_pkg;

    // Hold buffer depth default and cap on the minimum run length.
    localparam int HOLD_DEPTH_DEFAULT = 64;
    localparam int MIN_LEN_CAP        = 60;
    localparam logic [5:0] MIN_LEN_RESET = 6'd4;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_STR_END = 2'd1;
    localparam logic [1:0] KIND_PKT_END = 2'd2;

    // Printable range bounds (exclusive).
    localparam logic [7:0] PRINT_LOW  = 8'd31;
    localparam logic [7:0] PRINT_HIGH = 8'd127;

    // Frame layout and protocol codes.
    localparam logic [15:0] POS_ETYPE_HI      = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO      = 16'd13;
    localparam logic [15:0] POS_VLAN_ETYPE_HI = 16'd16;
    localparam logic [15:0] POS_VLAN_ETYPE_LO = 16'd17;
    localparam logic [4:0]  IP_START_PLAIN    = 5'd14;
    localparam logic [4:0]  IP_START_VLAN     = 5'd18;
    localparam logic [15:0] IP_PROTO_OFFSET   = 16'd9;
    localparam logic [7:0]  ETYPE_VLAN_HI     = 8'h81;
    localparam logic [7:0]  ETYPE_IPV4_HI     = 8'h08;
    localparam logic [7:0]  ETYPE_LO          = 8'h00;
    localparam logic [3:0]  MIN_HDR_WORDS     = 4'd5;
    localparam logic [7:0]  PROTO_TCP         = 8'd6;
    localparam logic [7:0]  PROTO_UDP         = 8'd17;
    localparam logic [15:0] UDP_HDR_LEN       = 16'd8;
    localparam logic [15:0] TCP_OFFSET_POS    = 16'd12;
    localparam logic [15:0] POS_MAX           = 16'hffff;
    localparam logic [5:0]  RUN_MAX           = 6'd63;

    // One input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } in_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic       keep;
        logic       last_of_item;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic flush_emit;
        logic tail_emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic plan_flush;
        logic plan_tail;
        logic flush_last;
        logic tail_any;
        logic tail_last;
        logic out_free;
    } ctrl_status_t;

endpackage

@@ rtl/ppse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ppse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ppse_ctrl.sv @@
// Controller state machine of the packet payload string extractor.
// Depends on ppse_pkg for the command and status structs.
module ppse_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_valid,
    output logic                  frame_stall,
    input  ppse_pkg::ctrl_status_t sts,
    output ppse_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_FLUSH_RD = 4'b0010,
        ST_FLUSH_WR = 4'b0100,
        ST_TAIL     = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Input is taken only when no results are outstanding.
    assign frame_stall = (state_reg != ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd.accept     = 1'b0;
        cmd.flush_emit = 1'b0;
        cmd.tail_emit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.plan_flush)
                    begin
                        state_next = ST_FLUSH_RD;
                    end
                    else if (sts.plan_tail)
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_FLUSH_RD:
            begin
                state_next = ST_FLUSH_WR;
            end
            ST_FLUSH_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.flush_emit = 1'b1;
                    if (!sts.flush_last)
                    begin
                        state_next = ST_FLUSH_RD;
                    end
                    else if (sts.tail_any)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.tail_emit = 1'b1;
                    if (sts.tail_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/ppse_datapath.sv @@
// Datapath of the packet payload string extractor: header parsing, run
// tracking, hold buffer, pending results and the output register.
// Depends on ppse_pkg and ppse_ram.
module ppse_datapath #(
    parameter int HOLD_DEPTH = ppse_pkg::HOLD_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ppse_pkg::in_t          frame_data,
    input  logic                   result_stall,
    output logic                   result_valid,
    output ppse_pkg::out_t         result_data,
    input  logic                   cfg_write_en,
    input  logic [5:0]             cfg_write_data,
    input  ppse_pkg::ctrl_cmd_t    cmd,
    output ppse_pkg::ctrl_status_t sts
);

    localparam int AW    = $clog2(HOLD_DEPTH);
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam logic [6:0] DEPTH7  = 7'(HOLD_DEPTH);
    localparam logic [5:0] THR_CAP =
        6'((ppse_pkg::MIN_LEN_CAP < HOLD_DEPTH) ? ppse_pkg::MIN_LEN_CAP : HOLD_DEPTH);

    // Bit positions of the pending single results, in emission order.
    localparam int PEND_CHAR   = 0;
    localparam int PEND_SEND   = 1;
    localparam int PEND_ENDSTR = 2;
    localparam int PEND_PKT    = 3;

    // Configuration and per-frame state.
    logic [5:0]  min_len_reg;
    logic [15:0] pos_reg, pos_next;
    logic        vlan_reg, vlan_next;
    logic [15:0] pstart_reg, pstart_next;
    logic        dropped_reg, dropped_next;
    logic [7:0]  eth_hi_reg, eth_hi_next;
    logic [5:0]  run_cnt_reg, run_cnt_next;
    logic        emitting_reg, emitting_next;
    logic        kept_reg, kept_next;
    logic        tcp_wait_reg, tcp_wait_next;

    // Pending results of the current transaction.
    logic [3:0]       pend_reg, pend_next, plan_pend;
    logic             keep_reg, plan_keep;
    logic [7:0]       cur_byte_reg;
    logic [CNT_W-1:0] flush_cnt_reg, plan_flush_cnt;
    logic [CNT_W-1:0] rd_idx_reg;

    // Output register.
    logic            out_valid_reg;
    ppse_pkg::out_t  out_data_reg, out_data_next;

    // Decode helpers.
    logic [7:0]  b;
    logic [15:0] ip_start_w;
    logic [15:0] ip_proto_pos;
    logic        printable;
    logic        zero_mode;
    logic [5:0]  thr;
    logic        hold_we;
    logic [7:0]  ram_rdata;
    logic        flush_last;

    assign b            = frame_data.data_byte;
    assign ip_start_w   = {11'd0, (vlan_reg ? ppse_pkg::IP_START_VLAN
                                            : ppse_pkg::IP_START_PLAIN)};
    assign ip_proto_pos = ip_start_w + ppse_pkg::IP_PROTO_OFFSET;
    assign printable    = (b > ppse_pkg::PRINT_LOW) && (b < ppse_pkg::PRINT_HIGH);
    assign zero_mode    = (min_len_reg == 6'd0);
    assign thr          = (min_len_reg > THR_CAP) ? THR_CAP : min_len_reg;

    // Parse the byte against the frame state and plan its results.
    always_comb
    begin
        pos_next       = pos_reg;
        vlan_next      = vlan_reg;
        pstart_next    = pstart_reg;
        dropped_next   = dropped_reg;
        eth_hi_next    = eth_hi_reg;
        run_cnt_next   = run_cnt_reg;
        emitting_next  = emitting_reg;
        kept_next      = kept_reg;
        tcp_wait_next  = tcp_wait_reg;
        plan_pend      = 4'd0;
        plan_keep      = 1'b0;
        plan_flush_cnt = '0;
        hold_we        = 1'b0;

        if (!dropped_reg)
        begin
            if (pos_reg == ppse_pkg::POS_ETYPE_HI)
            begin
                eth_hi_next = b;
            end
            else if (pos_reg == ppse_pkg::POS_ETYPE_LO)
            begin
                if ((eth_hi_reg == ppse_pkg::ETYPE_VLAN_HI) && (b == ppse_pkg::ETYPE_LO))
                begin
                    vlan_next = 1'b1;
                end
                else if (!((eth_hi_reg == ppse_pkg::ETYPE_IPV4_HI) &&
                           (b == ppse_pkg::ETYPE_LO)))
                begin
                    dropped_next = 1'b1;
                end
            end
            else if (vlan_reg && (pos_reg == ppse_pkg::POS_VLAN_ETYPE_HI))
            begin
                eth_hi_next = b;
            end
            else if (vlan_reg && (pos_reg == ppse_pkg::POS_VLAN_ETYPE_LO))
            begin
                if (!((eth_hi_reg == ppse_pkg::ETYPE_IPV4_HI) && (b == ppse_pkg::ETYPE_LO)))
                begin
                    dropped_next = 1'b1;
                end
            end
            else if (pos_reg == ip_start_w)
            begin
                if (b[3:0] < ppse_pkg::MIN_HDR_WORDS)
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    pstart_next = ip_start_w + 16'({b[3:0], 2'b00});
                end
            end
            else if (pos_reg == ip_proto_pos)
            begin
                if (b == ppse_pkg::PROTO_UDP)
                begin
                    pstart_next = pstart_reg + ppse_pkg::UDP_HDR_LEN;
                end
                else if (b == ppse_pkg::PROTO_TCP)
                begin
                    pstart_next   = pstart_reg + ppse_pkg::TCP_OFFSET_POS;
                    tcp_wait_next = 1'b1;
                end
            end
            else if (tcp_wait_reg && (pos_reg == pstart_reg))
            begin
                if (b[7:4] < ppse_pkg::MIN_HDR_WORDS)
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    pstart_next = pstart_reg - ppse_pkg::TCP_OFFSET_POS
                                + 16'({b[7:4], 2'b00});
                end
                tcp_wait_next = 1'b0;
            end
            else if ((pos_reg > ip_proto_pos) && !tcp_wait_reg && (pos_reg >= pstart_reg))
            begin
                // Payload byte: run tracking.
                if (printable)
                begin
                    if (emitting_reg)
                    begin
                        plan_pend[PEND_CHAR] = 1'b1;
                    end
                    else
                    begin
                        hold_we = ({1'b0, run_cnt_reg} < DEPTH7);
                        if (run_cnt_reg < ppse_pkg::RUN_MAX)
                        begin
                            run_cnt_next = run_cnt_reg + 6'd1;
                        end
                        if (zero_mode || (run_cnt_next >= thr))
                        begin
                            plan_flush_cnt = CNT_W'(({1'b0, run_cnt_next} >= DEPTH7)
                                                    ? DEPTH7 : {1'b0, run_cnt_next});
                            emitting_next  = 1'b1;
                            if (!zero_mode)
                            begin
                                kept_next = 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    if (zero_mode && emitting_reg)
                    begin
                        plan_pend[PEND_SEND] = 1'b1;
                        plan_keep            = (b == 8'd0);
                        if (b == 8'd0)
                        begin
                            kept_next = 1'b1;
                        end
                    end
                    run_cnt_next  = 6'd0;
                    emitting_next = 1'b0;
                end
            end
        end

        // Frame end closes an open run and reports the packet if a run was kept.
        if (frame_data.frame_last)
        begin
            plan_pend[PEND_ENDSTR] = emitting_next && zero_mode;
            plan_pend[PEND_PKT]    = kept_next;
            pos_next      = 16'd0;
            vlan_next     = 1'b0;
            pstart_next   = 16'd0;
            dropped_next  = 1'b0;
            eth_hi_next   = 8'd0;
            run_cnt_next  = 6'd0;
            emitting_next = 1'b0;
            kept_next     = 1'b0;
            tcp_wait_next = 1'b0;
        end
        else if (pos_reg != ppse_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 16'd1;
        end
    end

    // Hold buffer.
    ppse_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .clk   (clk),
        .we    (cmd.accept && hold_we),
        .waddr (run_cnt_reg[AW-1:0]),
        .wdata (b),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign flush_last = (CNT_W'(rd_idx_reg + 1'b1) == flush_cnt_reg);

    // Next output transaction and pending set.
    always_comb
    begin
        pend_next     = pend_reg;
        out_data_next = out_data_reg;
        if (cmd.flush_emit)
        begin
            out_data_next.kind         = ppse_pkg::KIND_CHAR;
            out_data_next.char_value   = ram_rdata;
            out_data_next.keep         = 1'b0;
            out_data_next.last_of_item = flush_last && (pend_reg == 4'd0);
        end
        else if (cmd.tail_emit)
        begin
            out_data_next.char_value   = 8'd0;
            out_data_next.keep         = 1'b0;
            out_data_next.last_of_item = ((pend_reg & (pend_reg - 4'd1)) == 4'd0);
            if (pend_reg[PEND_CHAR])
            begin
                out_data_next.kind       = ppse_pkg::KIND_CHAR;
                out_data_next.char_value = cur_byte_reg;
                pend_next[PEND_CHAR]     = 1'b0;
            end
            else if (pend_reg[PEND_SEND])
            begin
                out_data_next.kind   = ppse_pkg::KIND_STR_END;
                out_data_next.keep   = keep_reg;
                pend_next[PEND_SEND] = 1'b0;
            end
            else if (pend_reg[PEND_ENDSTR])
            begin
                out_data_next.kind     = ppse_pkg::KIND_STR_END;
                pend_next[PEND_ENDSTR] = 1'b0;
            end
            else
            begin
                out_data_next.kind  = ppse_pkg::KIND_PKT_END;
                pend_next[PEND_PKT] = 1'b0;
            end
        end
    end

    // Control and frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= ppse_pkg::MIN_LEN_RESET;
            pos_reg       <= 16'd0;
            vlan_reg      <= 1'b0;
            pstart_reg    <= 16'd0;
            dropped_reg   <= 1'b0;
            eth_hi_reg    <= 8'd0;
            run_cnt_reg   <= 6'd0;
            emitting_reg  <= 1'b0;
            kept_reg      <= 1'b0;
            tcp_wait_reg  <= 1'b0;
            pend_reg      <= 4'd0;
            flush_cnt_reg <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                min_len_reg <= cfg_write_data;
            end
            if (cmd.accept)
            begin
                pos_reg       <= pos_next;
                vlan_reg      <= vlan_next;
                pstart_reg    <= pstart_next;
                dropped_reg   <= dropped_next;
                eth_hi_reg    <= eth_hi_next;
                run_cnt_reg   <= run_cnt_next;
                emitting_reg  <= emitting_next;
                kept_reg      <= kept_next;
                tcp_wait_reg  <= tcp_wait_next;
                pend_reg      <= plan_pend;
                flush_cnt_reg <= plan_flush_cnt;
                rd_idx_reg    <= '0;
            end
            else
            begin
                pend_reg <= pend_next;
                if (cmd.flush_emit)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
            if (cmd.flush_emit || cmd.tail_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            keep_reg     <= plan_keep;
            cur_byte_reg <= b;
        end
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // Status to the controller.
    assign sts.plan_flush = (plan_flush_cnt != '0);
    assign sts.plan_tail  = (plan_pend != 4'd0);
    assign sts.flush_last = flush_last;
    assign sts.tail_any   = (pend_reg != 4'd0);
    assign sts.tail_last  = ((pend_reg & (pend_reg - 4'd1)) == 4'd0);
    assign sts.out_free   = !out_valid_reg || !result_stall;

endmodule

@@ rtl/packet_payload_string_extractor.sv @@
// A byte is taken while the controller is idle; its results are emitted from the TAIL
// state, and held characters are flushed from the hold RAM through FLUSH_RD and FLUSH_WR.
// Throughput: one byte per cycle while bytes cause no result; while results are sent the
// input stalls, and each flushed character is read through the registered hold RAM port.
// Reset clears all control and frame state and sets min_len to 4; the hold RAM is not
// cleared, as only entries written in the current run are read.
module packet_payload_string_extractor #(
    parameter int HOLD_DEPTH = ppse_pkg::HOLD_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           frame_valid,
    output logic           frame_stall,
    input  ppse_pkg::in_t  frame_data,
    output logic           result_valid,
    input  logic           result_stall,
    output ppse_pkg::out_t result_data,
    input  logic           cfg_write_en,
    input  logic [5:0]     cfg_write_data
);

    ppse_pkg::ctrl_cmd_t    cmd;
    ppse_pkg::ctrl_status_t sts;

    // Sequencing of transactions and their results.
    ppse_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Parsing, run tracking and result formation.
    ppse_datapath #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_data     (frame_data),
        .result_stall   (result_stall),
        .result_valid   (result_valid),
        .result_data    (result_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

@@ rtl/ppse_checker.sv @@
// Port-level checker for the packet payload string extractor, bound to the top level.
// Depends on ppse_pkg and packet_payload_string_extractor_defines.svh.
`include "packet_payload_string_extractor_defines.svh"

module ppse_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           result_valid,
    input logic           result_stall,
    input ppse_pkg::out_t result_data
);

    // A stalled result transaction holds.
    `PPSE_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result_data), "stalled result changed")

    // Only character results carry a character, and it is printable.
    `PPSE_ASSERT_NOW(a_char_zero, clk, rst_n, result_valid && (result_data.kind != ppse_pkg::KIND_CHAR), result_data.char_value == 8'd0, "non-character result carries a character")
    `PPSE_ASSERT_NOW(a_char_print, clk, rst_n, result_valid && (result_data.kind == ppse_pkg::KIND_CHAR), (result_data.char_value > ppse_pkg::PRINT_LOW) && (result_data.char_value < ppse_pkg::PRINT_HIGH), "character result not printable")

    // Keep is set only on string ends.
    `PPSE_ASSERT_NOW(a_keep_kind, clk, rst_n, result_valid && result_data.keep, result_data.kind == ppse_pkg::KIND_STR_END, "keep set outside a string end")

    // A packet end is always the final result of its byte.
    `PPSE_ASSERT_NOW(a_pkt_last, clk, rst_n, result_valid && (result_data.kind == ppse_pkg::KIND_PKT_END), result_data.last_of_item, "packet end not marked last")

endmodule

bind packet_payload_string_extractor ppse_checker u_ppse_checker (.*);
